>>> design/rmsn_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and the reciprocal square root seed table for rms normalization
// no dependencies

package rmsn_pkg;

  localparam int SUM_W  = 38;  // sum of squares, 24 fraction bits
  localparam int LEN_W  = 7;   // row length register
  localparam int EPS_W  = 16;  // epsilon register
  localparam int DATA_W = 16;  // q3.12 samples
  localparam int MEAN_W = 31;  // mean square plus epsilon, below 2^31
  localparam int Y_W    = 32;  // reciprocal square root, 30 fraction bits
  localparam int PROD_W = 64;  // shared multiplier product
  localparam int DIV_STEPS = SUM_W;
  localparam int NEWTON_STEPS = 3;

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPSILON_RESET    = 16'd17;

  localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [1:0] REG_EPSILON    = 2'd1;

  typedef enum logic [1:0] {
    MUL_SQ,   // y * y
    MUL_NS,   // n * s
    MUL_YD,   // y * d
    MUL_MAG   // |x * w| * y
  } mul_op_t;

  typedef struct packed {
    logic            load;        // input transaction
    logic            clear_row;
    logic            div_start;
    logic            div_step;
    logic            mean_load;
    logic            norm_init;
    logic            norm_step;
    logic            seed_load;
    logic            mul_en;
    mul_op_t         mul_op;
    logic            y_update;
    logic            xw_load;
    logic            round_load;
    logic [12:0]     rd_addr;     // element index, wide enough for depths up to 8192
    logic            last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             row_done;   // this transaction completes the row
    logic             n_low;      // normalization still needs a step
    logic [LEN_W-1:0] eff_len;
  } ctrl_status_t;

  function automatic logic [8:0] seed_lookup(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd4:  v = 9'd483;
      4'd5:  v = 9'd437;
      4'd6:  v = 9'd402;
      4'd7:  v = 9'd374;
      4'd8:  v = 9'd351;
      4'd9:  v = 9'd332;
      4'd10: v = 9'd316;
      4'd11: v = 9'd302;
      4'd12: v = 9'd290;
      4'd13: v = 9'd279;
      4'd14: v = 9'd269;
      4'd15: v = 9'd260;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/rms_normalization.sv
`timescale 1ns / 1ps
// top level of the rms normalization block: controller plus datapath
// uses rmsn_pkg, rmsn_ctrl, rmsn_datapath (which holds the rmsn_ram buffers)
//
// channel   direction  transaction payload
// s_axis    in         tdata[15:0] x_value, tdata[31:16] weight_value
// m_axis    out        tdata[15:0] y_value, tdata[21:16] element_index, tlast last_of_row
// cfg       in         cfg_index 0 row_length, 1 epsilon; cfg_data write value
//
// loading takes one element per cycle while s_axis_tvalid is high; after the last
// element of a row the serial divider runs its start and one step per bit of the sum,
// the mean is formed and normalized by two-bit shifts (at most 14 shifts), then the
// seed is loaded and the three newton steps run on the shared 32x32 multiplier
// emitting an element goes through ram read, x*w, scale, round and hand off, and the
// hand off waits while m_axis_tready is low; no input is taken while a row emits
// synchronous active-high reset; buffers keep their contents, counters clear

module rms_normalization import rmsn_pkg::*; #(
  parameter int ROW_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_value, weight_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // y_value, element_index, zero pad
  output logic        m_axis_tlast    // last_of_row
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic [15:0]  y_value;
  logic [5:0]   element_index;

  // sequencing of all phases
  rmsn_ctrl #(.ROW_DEPTH(ROW_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and storage
  rmsn_datapath #(.ROW_DEPTH(ROW_DEPTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .x_value       (s_axis_tdata[15:0]),
    .weight_value  (s_axis_tdata[31:16]),
    .cmd           (cmd),
    .status        (status),
    .y_value       (y_value),
    .element_index (element_index),
    .last_of_row   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, element_index, y_value};

  // a result is never pending while input is taken
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("result pending while input accepted");

  // after the last result of a row the block returns to loading
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("no return to loading after row end");

  // after a non-final result valid drops while the next element is computed
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result repeated without new computation");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

>>> design/rmsn_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module rmsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rmsn_datapath.sv
`timescale 1ns / 1ps
// datapath: row buffers, sum of squares, serial divider, normalizer, newton
// unit on a shared multiplier, output rounding; uses rmsn_pkg and rmsn_ram

module rmsn_datapath import rmsn_pkg::*; #(
  parameter int ROW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [EPS_W-1:0]    cfg_data,
  input  logic [DATA_W-1:0]   x_value,
  input  logic [DATA_W-1:0]   weight_value,
  input  ctrl_cmd_t           cmd,
  output ctrl_status_t        status,
  output logic [DATA_W-1:0]   y_value,
  output logic [5:0]          element_index,
  output logic                last_of_row
);
  localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int FW = $clog2(ROW_DEPTH + 1);
  localparam logic [Y_W-1:0] THREE = 32'hC000_0000;

  logic [LEN_W-1:0]  row_length;
  logic [EPS_W-1:0]  epsilon;
  logic [FW-1:0]     fill;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  quo;
  logic [LEN_W-1:0]  rem;
  logic [MEAN_W-1:0] mean;
  logic [MEAN_W-1:0] n;
  logic signed [4:0] j;
  logic              mz;
  logic [Y_W-1:0]    y;
  logic [PROD_W-1:0] prod;
  logic signed [31:0] xw;
  logic              neg;

  logic [LEN_W-1:0]  eff_len;
  logic signed [16:0] xs;
  logic [16:0]       ax;
  logic [33:0]       sq;
  logic [LEN_W:0]    div_trial;
  logic [Y_W-1:0]    mul_a;
  logic [Y_W-1:0]    mul_b;
  logic [Y_W-1:0]    t_val;
  logic [Y_W-1:0]    d_val;
  logic [30:0]       mag;
  logic [5:0]        sh;
  logic [PROD_W-1:0] rnd;
  logic [PROD_W-1:0] r;
  logic [DATA_W-1:0] y_sat;
  logic [DATA_W-1:0] x_rd;
  logic [DATA_W-1:0] w_rd;

  // row length of zero counts as one, anything above the buffer as the buffer
  always_comb begin
    if (row_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(row_length) > ROW_DEPTH) begin
      eff_len = LEN_W'(ROW_DEPTH);
    end else begin
      eff_len = row_length;
    end
  end

  assign status.eff_len  = eff_len;
  assign status.row_done = (32'(fill) + 32'd1) == 32'(eff_len);
  assign status.n_low    = !mz && (n < MEAN_W'(32'h1000_0000));

  assign xs = {x_value[DATA_W-1], x_value};
  assign ax = xs[16] ? 17'(-xs) : 17'(xs);
  assign sq = ax * ax;

  assign div_trial = {rem, quo[SUM_W-1]};

  rmsn_ram #(.WIDTH(DATA_W), .DEPTH(ROW_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill[AW-1:0]),
    .wdata (x_value),
    .raddr (cmd.rd_addr[AW-1:0]),
    .rdata (x_rd)
  );

  rmsn_ram #(.WIDTH(DATA_W), .DEPTH(ROW_DEPTH)) u_gain_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill[AW-1:0]),
    .wdata (weight_value),
    .raddr (cmd.rd_addr[AW-1:0]),
    .rdata (w_rd)
  );

  // newton correction term, clamped at zero
  assign t_val = prod[61:30];
  assign d_val = (t_val >= THREE) ? '0 : THREE - t_val;
  assign mag   = xw[31] ? 31'(-xw) : 31'(xw);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_SQ: begin
        mul_a = y;
        mul_b = y;
      end
      MUL_NS: begin
        mul_a = {1'b0, n};
        mul_b = prod[61:30];
      end
      MUL_YD: begin
        mul_a = y;
        mul_b = d_val;
      end
      MUL_MAG: begin
        mul_a = {1'b0, mag};
        mul_b = y;
      end
      default: begin
        mul_a = y;
        mul_b = y;
      end
    endcase
  end

  // round to nearest, ties away from zero, then saturate
  assign sh  = 6'(45 - int'(j));
  assign rnd = prod + (64'd1 << (sh - 6'd1));
  assign r   = rnd >> sh;

  always_comb begin
    if (neg) begin
      y_sat = (r > 64'd32768) ? 16'h8000 : 16'(-r);
    end else begin
      y_sat = (r > 64'd32767) ? 16'h7FFF : 16'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      epsilon    <= EPSILON_RESET;
      fill       <= '0;
      sum        <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_ROW_LENGTH) begin
        row_length <= cfg_data[LEN_W-1:0];
      end
      if (cfg_write && cfg_index == REG_EPSILON) begin
        epsilon <= cfg_data;
      end
      if (cmd.clear_row || (cfg_write && cfg_index == REG_ROW_LENGTH)) begin
        fill <= '0;
        sum  <= '0;
      end else if (cmd.load) begin
        fill <= fill + FW'(1);
        sum  <= sum + SUM_W'(sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (div_trial >= {1'b0, eff_len}) begin
        rem <= LEN_W'(div_trial - {1'b0, eff_len});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= div_trial[LEN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.mean_load) begin
      mean <= MEAN_W'(quo) + MEAN_W'(epsilon);
    end
    if (cmd.norm_init) begin
      if (mean == '0) begin
        mz <= 1'b1;
        n  <= '0;
        j  <= '0;
      end else if (mean[MEAN_W-1]) begin
        mz <= 1'b0;
        n  <= mean >> 2;
        j  <= -5'sd1;
      end else begin
        mz <= 1'b0;
        n  <= mean;
        j  <= '0;
      end
    end else if (cmd.norm_step) begin
      n <= n << 2;
      j <= j + 5'sd1;
    end
    if (cmd.seed_load) begin
      y <= mz ? '0 : Y_W'({seed_lookup(n[29:26]), 22'd0});
    end else if (cmd.y_update) begin
      y <= prod[62:31];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.xw_load) begin
      xw <= $signed(x_rd) * $signed(w_rd);
    end
    if (cmd.mul_en && cmd.mul_op == MUL_MAG) begin
      neg <= xw[31];
    end
    if (cmd.round_load) begin
      y_value       <= y_sat;
      element_index <= 6'(cmd.rd_addr);
      last_of_row   <= cmd.last;
    end
  end

endmodule

>>> design/rmsn_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences load, divide, normalize, newton and emit phases
// uses rmsn_pkg

module rmsn_ctrl import rmsn_pkg::*; #(
  parameter int ROW_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);
  localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_LOAD, S_DIV_START, S_DIV, S_MEAN, S_NORM_INIT, S_NORM, S_SEED,
    S_SQ, S_NS, S_YD, S_YUPD, S_RD, S_XW, S_MAG, S_RND, S_OUT
  } state_t;

  state_t        state;
  logic [5:0]    div_cnt;
  logic [1:0]    nt_cnt;
  logic [AW-1:0] idx;
  logic          idx_last;

  assign idx_last = (32'(idx) + 32'd1) == 32'(status.eff_len);
  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd            = '0;
    cmd.mul_op     = MUL_SQ;
    cmd.rd_addr    = 13'(idx);
    cmd.last       = idx_last;
    cmd.load       = (state == S_LOAD) && in_valid;
    cmd.clear_row  = (state == S_OUT) && out_ready && idx_last;
    cmd.div_start  = (state == S_DIV_START);
    cmd.div_step   = (state == S_DIV);
    cmd.mean_load  = (state == S_MEAN);
    cmd.norm_init  = (state == S_NORM_INIT);
    cmd.norm_step  = (state == S_NORM) && status.n_low;
    cmd.seed_load  = (state == S_SEED);
    cmd.y_update   = (state == S_YUPD);
    cmd.xw_load    = (state == S_XW);
    cmd.round_load = (state == S_RND);
    unique case (state)
      S_SQ:  begin cmd.mul_en = 1'b1; cmd.mul_op = MUL_SQ;  end
      S_NS:  begin cmd.mul_en = 1'b1; cmd.mul_op = MUL_NS;  end
      S_YD:  begin cmd.mul_en = 1'b1; cmd.mul_op = MUL_YD;  end
      S_MAG: begin cmd.mul_en = 1'b1; cmd.mul_op = MUL_MAG; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      div_cnt   <= '0;
      nt_cnt    <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid && status.row_done) begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(DIV_STEPS - 1)) begin
            state <= S_MEAN;
          end
        end
        S_MEAN:      state <= S_NORM_INIT;
        S_NORM_INIT: state <= S_NORM;
        S_NORM: begin
          if (!status.n_low) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          nt_cnt <= '0;
          state  <= S_SQ;
        end
        S_SQ: state <= S_NS;
        S_NS: state <= S_YD;
        S_YD: state <= S_YUPD;
        S_YUPD: begin
          nt_cnt <= nt_cnt + 2'd1;
          if (nt_cnt == 2'(NEWTON_STEPS - 1)) begin
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_SQ;
          end
        end
        S_RD:  state <= S_XW;
        S_XW:  state <= S_MAG;
        S_MAG: state <= S_RND;
        S_RND: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (idx_last) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
